@@ rtl/stbs_pkg.sv @@
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_ENTRY_WIDTH = 32;

    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;
    localparam int POS_W   = 8;

    // Input stream layout: tdata = {search_key, entry_value, slot}, tuser = func
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_CHK_FIRST,
        ST_PROBE,
        ST_CMP,
        ST_RESULT
    } state_t;

    // Outcome of the shared key/entry comparator
    typedef struct packed {
        logic gt;
        logic lt;
        logic eq;
    } cmp_t;

endpackage

@@ rtl/stbs_table.sv @@
// Entry memory: one write port, one read port with registered read data.
module stbs_table
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic signed [ENTRY_WIDTH-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic signed [ENTRY_WIDTH-1:0] rd_data
);

    logic signed [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/stbs_cmp.sv @@
// Shared signed comparator: search key against one table entry.
module stbs_cmp
    import stbs_pkg::*;
#(
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
)
(
    input  logic signed [KEY_W-1:0]       key,
    input  logic signed [ENTRY_WIDTH-1:0] entry,
    output cmp_t                          result
);

    localparam int CMP_W = (ENTRY_WIDTH > KEY_W) ? ENTRY_WIDTH : KEY_W;

    logic signed [CMP_W-1:0] key_ext;
    logic signed [CMP_W-1:0] entry_ext;

    // Sign-extend both sides to a common width
    assign key_ext   = CMP_W'(key);
    assign entry_ext = CMP_W'(entry);

    assign result.gt = key_ext > entry_ext;
    assign result.lt = key_ext < entry_ext;
    assign result.eq = key_ext == entry_ext;

endmodule

@@ rtl/stbs_ctrl.sv @@
// Search sequencer: bound checks, halving of the low/high bounds, result register.
module stbs_ctrl
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_func,
    input  logic signed [KEY_W-1:0] in_key,
    output logic                    in_ready,
    input  logic [ADDR_W-1:0]       last_idx,
    input  cmp_t                    cmp,
    output logic signed [KEY_W-1:0] key,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_found,
    output logic [POS_W-1:0]        out_pos
);

    state_t state_reg, state_next;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]       lo_reg, lo_next;
    logic [ADDR_W-1:0]       hi_reg, hi_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic                    final_reg, final_next;
    logic                    hit_reg, hit_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_found_reg, out_found_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;

    logic [ADDR_W:0]   bound_sum;
    logic [ADDR_W-1:0] mid_calc;
    logic              out_free;
    logic              search_go;

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = bound_sum[ADDR_W:1];
    assign out_free  = !out_valid_reg || out_ready;
    assign search_go = in_valid && (state_reg == ST_IDLE) && (in_func == FUNC_SEARCH);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (search_go)
                begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST:
            begin
                state_next = ST_RD_FIRST;
            end
            ST_RD_FIRST:
            begin
                state_next = cmp.gt ? ST_RESULT : ST_CHK_FIRST;
            end
            ST_CHK_FIRST:
            begin
                state_next = cmp.lt ? ST_RESULT : ST_PROBE;
            end
            ST_PROBE:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = (cmp.eq || final_reg) ? ST_RESULT : ST_PROBE;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = lo_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        final_next     = final_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (search_go)
                begin
                    key_next = in_key;
                    lo_next  = '0;
                    hi_next  = last_idx;
                    hit_next = 1'b0;
                end
            end
            ST_RD_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = hi_reg;
            end
            ST_RD_FIRST:
            begin
                // Last entry is on the read bus; fetch the first one
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_CHK_FIRST:
            begin
            end
            ST_PROBE:
            begin
                rd_en = 1'b1;
                if (hi_reg > lo_reg)
                begin
                    rd_addr    = mid_calc;
                    mid_next   = mid_calc;
                    final_next = 1'b0;
                end
                else
                begin
                    // Bounds have met: check the one remaining candidate
                    rd_addr    = lo_reg;
                    mid_next   = lo_reg;
                    final_next = 1'b1;
                end
            end
            ST_CMP:
            begin
                if (cmp.eq)
                begin
                    hit_next = 1'b1;
                end
                else if (cmp.gt)
                begin
                    lo_next = mid_reg + ADDR_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    out_pos_next   = hit_reg ? POS_W'(mid_reg) : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        final_reg     <= final_next;
        hit_reg       <= hit_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign key       = key_reg;
    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_pos   = out_pos_reg;

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// Top level of the sorted table binary search block.
//
// The block holds a table of signed entries, loaded in ascending order, and
// answers membership queries by binary search. A load transaction (tuser = 0)
// writes one entry when accepted and gives no result; the block is ready
// again at once. A search transaction (tuser = 1) gives exactly one result
// transaction: tuser = found, tdata = slot of the match (zero when not found).
// A search occupies the block until its result is loaded into the output
// register; each probe first reads the entry memory and then runs the
// shared comparator and halves the bounds. A key above the last entry is
// rejected once the last entry has been read, and a key below the first
// entry once the first entry has been read. The result waits in an
// output register until taken. Write entry_count only while no search is
// in flight; a count of zero acts as one and a count above the table depth
// acts as the depth. Load the entries before searching them.
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration: entry_count
    input  logic                   cfg_wr_en,
    input  logic [COUNT_W-1:0]     cfg_wr_data,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // slot[7:0], entry_value[39:8], search_key[71:40]
    input  logic                   s_axis_tuser,  // func
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // position[7:0]
    output logic                   m_axis_tuser   // found
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [COUNT_W-1:0]            entry_count_reg;
    logic [ADDR_W-1:0]             last_idx;
    logic [SLOT_W-1:0]             in_slot;
    logic signed [KEY_W-1:0]       in_value;
    logic signed [KEY_W-1:0]       in_key;
    logic                          load_wr;
    logic signed [KEY_W-1:0]       key;
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic signed [ENTRY_WIDTH-1:0] rd_data;
    cmp_t                          cmp;

    assign in_slot  = s_axis_tdata[SLOT_W-1:0];
    assign in_value = s_axis_tdata[SLOT_W+KEY_W-1:SLOT_W];
    assign in_key   = s_axis_tdata[SLOT_W+2*KEY_W-1:SLOT_W+KEY_W];

    // Hold the entry count; reset to one entry in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= COUNT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    // Index of the last entry in use, clamped to the table
    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(entry_count_reg) > 32'(TABLE_DEPTH))
        begin
            last_idx = ADDR_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_idx = ADDR_W'(entry_count_reg - COUNT_W'(1));
        end
    end

    // Write on a load transaction; drop slots beyond the table
    assign load_wr = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOAD)
                     && (32'(in_slot) < 32'(TABLE_DEPTH));

    stbs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (ADDR_W'(in_slot)),
        .wr_data (ENTRY_WIDTH'(in_value)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_cmp #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cmp (
        .key    (key),
        .entry  (rd_data),
        .result (cmp)
    );

    stbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_func   (s_axis_tuser),
        .in_key    (in_key),
        .in_ready  (s_axis_tready),
        .last_idx  (last_idx),
        .cmp       (cmp),
        .key       (key),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_found (m_axis_tuser),
        .out_pos   (m_axis_tdata)
    );

endmodule

@@ rtl/stbs_checker.sv @@
// Port-level checks for the sorted table binary search block, bound to the top level.
module stbs_checker
    import stbs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A search transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_SEARCH) |=> !s_axis_tready)
        else $error("input ready right after a search transaction");

    // A miss reports position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("not-found result with non-zero position");

    // A new result only appears at the end of a busy search
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised without a search in flight");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
